// ===== hdl/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types for the Bresenham line stepper: the action code of an input item.
// ----------------------------------------------------------------------------
package bls_pkg;

    typedef enum logic
    {
        ACTION_START = 1'b0,
        ACTION_STEP  = 1'b1
    } action_t;

endpackage

// ===== hdl/bls_if.sv =====
// ----------------------------------------------------------------------------
// bls_in_if / bls_out_if
// Valid/ready channels of the line stepper: commands in, pixels out.
// ----------------------------------------------------------------------------
interface bls_in_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
);
    logic                         valid;
    logic                         ready;
    action_t                      action;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [COLOR_BITS-1:0] line_color;

    modport source (output valid, action, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, action, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

interface bls_out_if
#(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic        [COLOR_BITS-1:0] pixel_color;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== hdl/bresenham_line_stepper_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core
// Integer Bresenham line stepper covering all eight octants.
// ----------------------------------------------------------------------------
// Usage:
//   req carries items: action START latches start point, slope and color and
//   yields the first pixel; action STEP yields the next pixel of the line.
//   A STEP while no line is active yields nothing. A START while a line is
//   active drops it. pix carries one pixel per producing item; last_pixel
//   marks the second endpoint (a zero-length line gives one such pixel).
// Output: the pixel of an accepted item is registered in the output register.
// Throughput: one item per cycle while pix keeps taking pixels. The line state
//   (position, error term, step count) is updated by one add/compare per accepted
//   item, and the output register frees as soon as pix takes its pixel.
// Stall: while the output register holds a pixel that pix does not take,
//   req.ready is low and the line state holds.
// Reset: rst_n clears the active-line flag, the step count and the output valid
//   flag; the block comes up idle with no pixel pending.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    bls_in_if.sink     req,
    bls_out_if.source  pix
);

    localparam int ERR_BITS = COORD_BITS + 3;

    logic                         busy_reg,       busy_next;
    logic signed [COORD_BITS-1:0] cur_x_reg,      cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,      cur_y_next;
    logic signed [ERR_BITS-1:0]   err_reg,        err_next;
    logic        [COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic        [COORD_BITS-1:0] major_reg,      major_next;
    logic        [COORD_BITS-1:0] minor_reg,      minor_next;
    logic                         x_major_reg,    x_major_next;
    logic                         x_down_reg,     x_down_next;
    logic                         y_down_reg,     y_down_next;
    logic        [COLOR_BITS-1:0] color_reg,      color_next;
    logic                         out_valid_reg,  out_valid_next;
    logic                         out_last_reg,   out_last_next;

    logic                         in_acc;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic                         start_x_major;
    logic        [COORD_BITS-1:0] start_major;
    logic        [COORD_BITS-1:0] start_minor;
    logic                         err_ge;
    logic signed [ERR_BITS-1:0]   err_sub;

    assign req.ready = !out_valid_reg || pix.ready;
    assign in_acc    = req.valid && req.ready;

    assign dx  = {req.end_x[COORD_BITS-1], req.end_x} - {req.start_x[COORD_BITS-1], req.start_x};
    assign dy  = {req.end_y[COORD_BITS-1], req.end_y} - {req.start_y[COORD_BITS-1], req.start_y};
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign start_x_major = ady <= adx;
    assign start_major   = start_x_major ? adx : ady;
    assign start_minor   = start_x_major ? ady : adx;

    assign err_ge  = !err_reg[ERR_BITS-1];
    assign err_sub = err_ge ? err_reg - $signed({2'b00, major_reg, 1'b0}) : err_reg;

    always_comb
    begin
        busy_next       = busy_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_next        = err_reg;
        steps_left_next = steps_left_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        x_major_next    = x_major_reg;
        x_down_next     = x_down_reg;
        y_down_next     = y_down_reg;
        color_next      = color_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !pix.ready;

        if (in_acc)
        begin
            unique case (req.action)
                ACTION_START:
                begin
                    x_down_next     = req.start_x > req.end_x;
                    y_down_next     = req.start_y > req.end_y;
                    x_major_next    = start_x_major;
                    major_next      = start_major;
                    minor_next      = start_minor;
                    err_next        = $signed({2'b00, start_minor, 1'b0})
                                    - $signed({3'b000, start_major});
                    steps_left_next = start_major;
                    cur_x_next      = req.start_x;
                    cur_y_next      = req.start_y;
                    color_next      = req.line_color;
                    busy_next       = start_major != '0;
                    out_last_next   = start_major == '0;
                    out_valid_next  = 1'b1;
                end
                ACTION_STEP:
                begin
                    if (busy_reg)
                    begin
                        if (x_major_reg || err_ge)
                            cur_x_next = x_down_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                        if (!x_major_reg || err_ge)
                            cur_y_next = y_down_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        err_next        = err_sub + $signed({2'b00, minor_reg, 1'b0});
                        steps_left_next = steps_left_reg - 1'b1;
                        busy_next       = steps_left_reg != COORD_BITS'(1);
                        out_last_next   = steps_left_reg == COORD_BITS'(1);
                        out_valid_next  = 1'b1;
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !pix.ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            steps_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            steps_left_reg <= steps_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        err_reg      <= err_next;
        major_reg    <= major_next;
        minor_reg    <= minor_next;
        x_major_reg  <= x_major_next;
        x_down_reg   <= x_down_next;
        y_down_reg   <= y_down_next;
        color_reg    <= color_next;
        out_last_reg <= out_last_next;
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = cur_x_reg;
    assign pix.pixel_y     = cur_y_reg;
    assign pix.pixel_color = color_reg;
    assign pix.last_pixel  = out_last_reg;

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (steps_left_reg != '0))
        else $error("active-line flag disagrees with step count");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req.action == ACTION_STEP && !busy_reg |=> !pix.valid)
        else $error("step while idle produced a pixel");

    a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req.action == ACTION_START
        |=> pix.valid && pix.pixel_x == $past(req.start_x)
            && pix.pixel_y == $past(req.start_y))
        else $error("start item did not yield its first endpoint");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.last_pixel |-> !busy_reg)
        else $error("last pixel pending while line still active");

endmodule
